/* hdl/pdu_frame_checker_unit_defines.svh */
// Assertion macros for the frame checker
`ifndef PDU_FRAME_CHECKER_UNIT_DEFINES_SVH
`define PDU_FRAME_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication
`define PFC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame checker assertion failed");

// Next-cycle implication
`define PFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame checker assertion failed");

`endif

/* hdl/pfc_pkg.sv */
// Shared types and constants of the frame checker
package pfc_pkg;

   localparam int HEADER_BYTES = 10;
   localparam int QUEUE_DEPTH  = 2;
   localparam int POS_W        = 17;

   localparam logic [7:0] MAGIC_BYTE = 8'hA0;

   localparam logic [1:0] MODE_HEADER = 2'd0;
   localparam logic [1:0] MODE_REPLY  = 2'd1;
   localparam logic [1:0] MODE_HELLO  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
   localparam logic [2:0] ST_BAD_DIR   = 3'd2;
   localparam logic [2:0] ST_LEN_ERR   = 3'd3;
   localparam logic [2:0] ST_NO_BLOCKS = 3'd4;
   localparam logic [2:0] ST_BLOCK_BAD = 3'd5;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] frame_type;
      logic [7:0]  func_code;
      logic [7:0]  direction;
      logic [15:0] body_length;
      logic [15:0] bad_block_index;
      logic [15:0] record_count;
   } rsp_type;

   // Byte tagged with its position in the frame
   typedef struct packed {
      logic [7:0]       byte_value;
      logic             frame_start;
      logic [POS_W-1:0] position;
   } item_type;

endpackage

/* hdl/pdu_frame_checker_unit.sv */
// Top level of the frame checker
//  channel  | ports                        | moves
//  request  | req_valid req_ready req_data | one frame byte per beat
//  response | rsp_valid rsp_ready rsp_data | one frame result per beat
//  csr      | csr_wr_en csr_wr_data        | body_mode write, no wait
// One byte per cycle while the response is not stalled; a byte passes the front stage
// and the queue, and its result, if any, is registered in the response register after
// the queue entry and the back stage's check, later while the response is stalled.
// The back stage's per-byte check sets the rate.
// Synchronous reset clears control; body_mode resets to reply walk.
// A stalled response holds the back stage; the queue absorbs two beats first.
module pdu_frame_checker_unit #(
   parameter int QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pfc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pfc_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data
);

   logic [1:0] mode_ff;
   logic       push, full, not_empty, pop;
   pfc_pkg::item_type push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pfc_pkg::MODE_REPLY;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   pfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_item  (push_item),
      .queue_full (full)
   );

   pfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_item  (pop_item)
   );

   logic back_ready;
   assign pop = not_empty && back_ready;

   pfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .body_mode  (mode_ff),
      .item_valid (not_empty),
      .item_ready (back_ready),
      .item       (pop_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* hdl/pfc_front.sv */
// Front end: accepts bytes and tags each with its frame position
module pfc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pfc_pkg::req_type  req_data,
   output logic              push,
   output pfc_pkg::item_type push_item,
   input  logic              queue_full
);

   logic [pfc_pkg::POS_W-1:0] pos_ff;
   logic [pfc_pkg::POS_W-1:0] pos_in;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      if (req_data.frame_start) begin
         pos_in = '0;
      end else if (pos_ff == '1) begin
         pos_in = pos_ff;   // hold at top, only bytes outside a frame get here
      end else begin
         pos_in = pos_ff + 1'b1;
      end
   end

   assign push_item.byte_value  = req_data.byte_value;
   assign push_item.frame_start = req_data.frame_start;
   assign push_item.position    = pos_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '1;
      end else if (push) begin
         pos_ff <= pos_in;
      end
   end

endmodule

/* hdl/pfc_queue.sv */
// Short queue between front and back
module pfc_queue #(
   parameter int DEPTH = pfc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfc_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output pfc_pkg::item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pfc_pkg::item_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_item  = mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hdl/pfc_back.sv */
// Back end: header and body checks, result register
module pfc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        body_mode,
   input  logic              item_valid,
   output logic              item_ready,
   input  pfc_pkg::item_type item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pfc_pkg::rsp_type  rsp_data
);

   localparam int PW = pfc_pkg::POS_W;

   logic        active_ff, active_in;
   logic        body_ff, body_in;
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] type_ff, type_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  dir_ff, dir_in;
   logic [7:0]  lenhi_ff, lenhi_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] blk_ff, blk_in;
   logic [PW-1:0] off_ff, off_in;
   logic [15:0] size_ff, size_in;
   logic [2:0]  err_ff, err_in;
   logic [15:0] errblk_ff, errblk_in;
   logic [15:0] hello_ff, hello_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pfc_pkg::rsp_type rsp_ff, rsp_in;

   logic take;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign take       = item_valid && item_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      logic          emit;
      logic [2:0]    st;
      logic [7:0]    b;
      logic [PW-1:0] pos;
      logic [PW-1:0] p;
      logic [17:0]  blk_end;
      logic [19:0]  hello_len;
      active_in = active_ff;
      body_in   = body_ff;
      mode_in   = mode_ff;
      type_in   = type_ff;
      func_in   = func_ff;
      dir_in    = dir_ff;
      lenhi_in  = lenhi_ff;
      len_in    = len_ff;
      total_in  = total_ff;
      blk_in    = blk_ff;
      off_in    = off_ff;
      size_in   = size_ff;
      err_in    = err_ff;
      errblk_in = errblk_ff;
      hello_in  = hello_ff;
      emit      = 1'b0;
      st        = pfc_pkg::ST_OK;
      b         = item.byte_value;
      pos       = item.position;
      p         = pos - PW'(pfc_pkg::HEADER_BYTES);
      blk_end   = '0;
      hello_len = '0;

      if (item.frame_start) begin
         active_in = 1'b1;
         body_in   = 1'b0;
         mode_in   = body_mode;
         type_in   = '0;
         func_in   = '0;
         dir_in    = '0;
         lenhi_in  = '0;
         len_in    = '0;
         total_in  = '0;
         blk_in    = '0;
         off_in    = PW'(2);
         size_in   = '0;
         err_in    = pfc_pkg::ST_OK;
         errblk_in = '0;
         hello_in  = '0;
      end

      if (active_in && !body_in) begin
         if (pos < PW'(4)) begin
            if (b != pfc_pkg::MAGIC_BYTE) begin
               emit = 1'b1;
               st   = pfc_pkg::ST_BAD_MAGIC;
            end
         end else if (pos < PW'(pfc_pkg::HEADER_BYTES - 1)) begin
            case (pos[2:0])
               3'd4:    type_in[15:8] = b;
               3'd5:    type_in[7:0]  = b;
               3'd6:    func_in       = b;
               3'd7: begin
                  dir_in = b;
                  if (b < 8'd1 || b > 8'd4) begin
                     emit = 1'b1;
                     st   = pfc_pkg::ST_BAD_DIR;
                  end
               end
               default: lenhi_in      = b;
            endcase
         end else begin
            len_in  = {lenhi_in, b};
            body_in = 1'b1;
            if (len_in == '0) begin
               emit = 1'b1;
            end
         end
      end else if (active_in) begin
         if (mode_in == pfc_pkg::MODE_REPLY) begin
            if (p == '0) begin
               total_in = {b, 8'h00};
            end else if (p == PW'(1)) begin
               total_in[7:0] = b;
               if (total_in == '0 && err_in == pfc_pkg::ST_OK) begin
                  err_in = pfc_pkg::ST_NO_BLOCKS;
               end
            end else if (err_in == pfc_pkg::ST_OK && blk_in < total_in) begin
               if (p == off_in) begin
                  size_in = {b, 8'h00};
               end else if (p == off_in + 1'b1) begin
                  size_in[7:0] = b;
                  blk_end = {1'b0, off_in} + {2'b00, size_in};
                  if (size_in < 16'd10 || blk_end > {2'b00, len_in}) begin
                     err_in = pfc_pkg::ST_LEN_ERR;
                  end
               end else if (p == off_in + PW'(8) || p == off_in + PW'(9)) begin
                  if (b != '0) begin
                     err_in    = pfc_pkg::ST_BLOCK_BAD;
                     errblk_in = blk_in;
                  end
                  if (p == off_in + PW'(9) && err_in == pfc_pkg::ST_OK) begin
                     blk_in = blk_in + 1'b1;
                     off_in = off_in + PW'(size_in);
                  end
               end
            end
         end else if (mode_in == pfc_pkg::MODE_HELLO) begin
            if (p == PW'(8)) begin
               hello_in[15:8] = b;
            end else if (p == PW'(9)) begin
               hello_in[7:0] = b;
            end
         end
         if ({1'b0, p} + 1'b1 >= {2'b00, len_in}) begin
            emit = 1'b1;
         end
      end

      // final verdict on the last byte of the frame
      if (emit && body_in) begin
         hello_len = {1'b0, hello_in, 3'b000} + 20'd16;
         if (mode_in == pfc_pkg::MODE_REPLY) begin
            if (err_in == pfc_pkg::ST_OK) begin
               if (len_in < 16'd2) begin
                  err_in = pfc_pkg::ST_NO_BLOCKS;
               end else if (blk_in < total_in) begin
                  err_in = pfc_pkg::ST_LEN_ERR;
               end
            end
            st = err_in;
         end else if (mode_in == pfc_pkg::MODE_HELLO) begin
            if (len_in < 16'd16 || {4'b0000, len_in} != hello_len) begin
               st = pfc_pkg::ST_LEN_ERR;
            end else begin
               st = pfc_pkg::ST_OK;
            end
         end else begin
            st = pfc_pkg::ST_OK;
         end
      end

      if (emit) begin
         active_in = 1'b0;
      end

      rsp_in.status          = st;
      rsp_in.frame_type      = type_in;
      rsp_in.func_code       = func_in;
      rsp_in.direction       = dir_in;
      rsp_in.body_length     = len_in;
      rsp_in.bad_block_index = (st == pfc_pkg::ST_BLOCK_BAD) ? errblk_in : '0;
      rsp_in.record_count    = (mode_in == pfc_pkg::MODE_HELLO && st == pfc_pkg::ST_OK)
                               ? hello_in : '0;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         body_ff      <= 1'b0;
         mode_ff      <= pfc_pkg::MODE_REPLY;
         rsp_valid_ff <= 1'b0;
         err_ff       <= pfc_pkg::ST_OK;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            active_ff <= active_in;
            body_ff   <= body_in;
            mode_ff   <= mode_in;
            err_ff    <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         type_ff   <= type_in;
         func_ff   <= func_in;
         dir_ff    <= dir_in;
         lenhi_ff  <= lenhi_in;
         len_ff    <= len_in;
         total_ff  <= total_in;
         blk_ff    <= blk_in;
         off_ff    <= off_in;
         size_ff   <= size_in;
         errblk_ff <= errblk_in;
         hello_ff  <= hello_in;
      end
      if (take && rsp_valid_in && item_ready) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* hdl/pfc_checker.sv */
// Port-level checks of the frame checker and their binding
`include "pdu_frame_checker_unit_defines.svh"

module pfc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pfc_pkg::rsp_type rsp_data
);

   logic rsp_stall, rsp_magic, rsp_not_bad, rsp_not_ok, hdr_zero;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_magic   = rsp_valid && rsp_data.status == pfc_pkg::ST_BAD_MAGIC;
   assign rsp_not_bad = rsp_valid && rsp_data.status != pfc_pkg::ST_BLOCK_BAD;
   assign rsp_not_ok  = rsp_valid && rsp_data.status != pfc_pkg::ST_OK;
   assign hdr_zero    = rsp_data.frame_type == '0 && rsp_data.body_length == '0;

   `PFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   `PFC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_data))
   `PFC_ASSERT_NOW(a_magic_empty, clock, reset, rsp_magic, hdr_zero)
   `PFC_ASSERT_NOW(a_index_only_bad, clock, reset, rsp_not_bad, rsp_data.bad_block_index == '0)
   `PFC_ASSERT_NOW(a_count_only_ok, clock, reset, rsp_not_ok, rsp_data.record_count == '0)

endmodule

bind pdu_frame_checker_unit pfc_checker u_pfc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
